// ===== design/fps_pkg.sv =====
// Shared types, constants and codes for the farthest point sampling block.
// No dependencies; every other file imports this package.
package fps_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS + 2;
  localparam int DIST_W     = 2 * COORD_BITS + 3;
  localparam int START_W    = 10;
  localparam int LIMIT_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [DIST_W-1:0]  DIST_ONES    = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX      = CNT_W'(MAX_POINTS);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(1024);

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_BAD_START = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LIMIT = 2'd1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } fps_point_t;

  typedef struct packed {
    logic             issue;
    logic             last;
    logic             first;
    logic [IDX_W-1:0] idx;
  } fps_sweep_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] idx;
  } fps_best_t;

endpackage

// ===== design/fps_point_mem.sv =====
// Point coordinate memory: one write port for loads, one registered read port.
// Depends on fps_pkg.
module fps_point_mem import fps_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  fps_point_t       wr_data_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output fps_point_t       rd_data_o
);

  fps_point_t mem [MAX_POINTS];
  fps_point_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/fps_dist_pipe.sv =====
// Distance pipeline: squared distance to the reference point, minimum update
// in the distance memory, and running maximum search. Depends on fps_pkg.
module fps_dist_pipe import fps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fps_sweep_t sweep_i,
  input  fps_point_t ref_i,
  input  fps_point_t pt_i,
  output fps_best_t  best_o
);

  logic [DIST_W-1:0] min_mem [MAX_POINTS];
  logic [DIST_W-1:0] min_rd_q;

  logic             s1_vld_q, s1_last_q;
  logic [IDX_W-1:0] s1_idx_q;

  logic                     s2_vld_q, s2_last_q;
  logic [IDX_W-1:0]         s2_idx_q;
  logic signed [DIFF_W-1:0] s2_dx_q, s2_dy_q, s2_dz_q;
  logic [DIST_W-1:0]        s2_min_q;

  logic              s3_vld_q, s3_last_q;
  logic [IDX_W-1:0]  s3_idx_q;
  logic [SQ_W-1:0]   s3_sx_q, s3_sy_q, s3_sz_q;
  logic [DIST_W-1:0] s3_min_q;

  logic              s4_vld_q, s4_last_q;
  logic [IDX_W-1:0]  s4_idx_q;
  logic [DIST_W-1:0] s4_sum_q, s4_min_q;

  logic              s5_vld_q, s5_last_q;
  logic [IDX_W-1:0]  s5_idx_q;
  logic [DIST_W-1:0] s5_min_q;
  logic [DIST_W-1:0] new_min_d;

  logic              done_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [DIST_W-1:0] best_dist_q;

  logic signed [2*DIFF_W-1:0] px, py, pz;

  assign new_min_d = (s4_sum_q < s4_min_q) ? s4_sum_q : s4_min_q;
  assign px = s2_dx_q * s2_dx_q;
  assign py = s2_dy_q * s2_dy_q;
  assign pz = s2_dz_q * s2_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= sweep_i.issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      done_q   <= s5_vld_q & s5_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    min_rd_q  <= min_mem[sweep_i.idx];
    s1_idx_q  <= sweep_i.idx;
    s1_last_q <= sweep_i.last;

    s2_idx_q  <= s1_idx_q;
    s2_last_q <= s1_last_q;
    s2_dx_q   <= DIFF_W'(pt_i.x) - DIFF_W'(ref_i.x);
    s2_dy_q   <= DIFF_W'(pt_i.y) - DIFF_W'(ref_i.y);
    s2_dz_q   <= DIFF_W'(pt_i.z) - DIFF_W'(ref_i.z);
    s2_min_q  <= sweep_i.first ? DIST_ONES : min_rd_q;

    s3_idx_q  <= s2_idx_q;
    s3_last_q <= s2_last_q;
    s3_sx_q   <= SQ_W'(px);
    s3_sy_q   <= SQ_W'(py);
    s3_sz_q   <= SQ_W'(pz);
    s3_min_q  <= s2_min_q;

    s4_idx_q  <= s3_idx_q;
    s4_last_q <= s3_last_q;
    s4_sum_q  <= DIST_W'(s3_sx_q) + DIST_W'(s3_sy_q) + DIST_W'(s3_sz_q);
    s4_min_q  <= s3_min_q;

    s5_idx_q  <= s4_idx_q;
    s5_last_q <= s4_last_q;
    s5_min_q  <= new_min_d;
    if (s4_vld_q) begin
      min_mem[s4_idx_q] <= new_min_d;
    end

    if (s5_vld_q && (s5_idx_q == '0 || s5_min_q > best_dist_q)) begin
      best_dist_q <= s5_min_q;
      best_idx_q  <= s5_idx_q;
    end
  end

  assign best_o.done = done_q;
  assign best_o.idx  = best_idx_q;

endmodule

// ===== design/farthest_point_sampling_top.sv =====
// Farthest point sampling top level: command decode, sweep sequencer, result.
// Depends on fps_pkg, fps_point_mem and fps_dist_pipe.
//
//   channel   handshake                 words
//   command   start_i & !busy_o         action_i, coord_x_i, coord_y_i, coord_z_i
//   config    cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//   result    result_valid_o, 1 cycle   sample_index_o, status_o
//
// Clear and load are handled in idle and busy_o stays low. A first sample or an
// error result shows in the cycle after the command. A later sample sweeps the
// point memory at one point per cycle through the distance pipeline.
// The result shows for one cycle; the receiver cannot stall it.
// Reset is asynchronous, active low; the memories need no clearing pass.
module farthest_point_sampling_top import fps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            action_i,
  input  logic [15:0]           coord_x_i,
  input  logic [15:0]           coord_y_i,
  input  logic [15:0]           coord_z_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  result_valid_o,
  output logic [9:0]            sample_index_o,
  output logic [1:0]            status_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_REF   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   taken_q, taken_d;
  logic [IDX_W-1:0]   last_q, last_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               first_q, first_d;
  logic [START_W-1:0] start_idx_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               res_vld_q, res_vld_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic [1:0]         res_st_q, res_st_d;

  fps_point_t ref_q, ref_d;
  fps_point_t wr_pt, rd_pt;
  logic       accept, mem_we;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] end_idx;
  fps_sweep_t sweep;
  fps_best_t  best;

  assign accept  = start_i & (state_q == S_IDLE);
  assign end_idx = IDX_W'(count_q - CNT_W'(1));
  assign wr_pt.x = coord_x_i[COORD_BITS-1:0];
  assign wr_pt.y = coord_y_i[COORD_BITS-1:0];
  assign wr_pt.z = coord_z_i[COORD_BITS-1:0];
  assign mem_we  = accept && action_i == ACT_LOAD && count_q < CNT_MAX;
  assign rd_addr = (state_q == S_SWEEP) ? idx_q : last_q;

  assign sweep.issue = (state_q == S_SWEEP);
  assign sweep.last  = (idx_q == end_idx);
  assign sweep.first = first_q;
  assign sweep.idx   = idx_q;

  fps_point_mem u_point_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (wr_pt),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_pt)
  );

  fps_dist_pipe u_dist_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sweep_i (sweep),
    .ref_i   (ref_q),
    .pt_i    (rd_pt),
    .best_o  (best)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    taken_d   = taken_q;
    last_d    = last_q;
    idx_d     = idx_q;
    first_d   = first_q;
    ref_d     = ref_q;
    res_vld_d = 1'b0;
    res_idx_d = res_idx_q;
    res_st_d  = res_st_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_CLEAR: begin
              count_d = '0;
              taken_d = '0;
              last_d  = '0;
            end
            ACT_LOAD: begin
              if (count_q < CNT_MAX) begin
                count_d = count_q + CNT_W'(1);
                taken_d = '0;
              end
            end
            ACT_SAMPLE: begin
              res_vld_d = 1'b1;
              res_idx_d = '0;
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
              end else if (taken_q >= CNT_W'(limit_q) || taken_q >= count_q) begin
                res_st_d = ST_EXHAUSTED;
              end else if (taken_q == '0) begin
                if (CNT_W'(start_idx_q) >= count_q) begin
                  res_st_d = ST_BAD_START;
                end else begin
                  res_st_d  = ST_OK;
                  res_idx_d = IDX_W'(start_idx_q);
                  last_d    = IDX_W'(start_idx_q);
                  taken_d   = CNT_W'(1);
                end
              end else begin
                res_vld_d = 1'b0;
                first_d   = (taken_q == CNT_W'(1));
                state_d   = S_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        state_d = S_REF;
      end
      S_REF: begin
        ref_d   = rd_pt;
        idx_d   = '0;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == end_idx) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (best.done) begin
          res_vld_d = 1'b1;
          res_idx_d = best.idx;
          res_st_d  = ST_OK;
          last_d    = best.idx;
          taken_d   = taken_q + CNT_W'(1);
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      taken_q     <= '0;
      last_q      <= '0;
      idx_q       <= '0;
      first_q     <= 1'b0;
      res_vld_q   <= 1'b0;
      start_idx_q <= '0;
      limit_q     <= LIMIT_RESET;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      taken_q   <= taken_d;
      last_q    <= last_d;
      idx_q     <= idx_d;
      first_q   <= first_d;
      res_vld_q <= res_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_START_INDEX:  start_idx_q <= cfg_data_i[START_W-1:0];
          CFG_SAMPLE_LIMIT: limit_q     <= cfg_data_i[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ref_q     <= ref_d;
    res_idx_q <= res_idx_d;
    res_st_q  <= res_st_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_vld_q;
  assign sample_index_o = res_idx_q;
  assign status_o       = res_st_q;

endmodule
